// File: hw/rtl/bcc_pkg.sv
// Shared types, command encodings and constants for the balance cascade controller.
package bcc_pkg;

  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PSUM_W    = 20;
  localparam int FILT_W    = 28;
  localparam int TERM_W    = 32;
  localparam int CMD_W     = 3;

  localparam int SET_SPEED   = 40;
  localparam int SET_TURN    = 50;
  localparam int INTEG_LIMIT = 3000;

  localparam logic [7:0] DUTY_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_BAL_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAL_D = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_I = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN  = 3'd4;

  localparam logic [GAIN_W-1:0] BAL_P_RST = 16'd14080;
  localparam logic [GAIN_W-1:0] BAL_D_RST = 16'd192;
  localparam logic [GAIN_W-1:0] SPD_P_RST = 16'd2560;
  localparam logic [GAIN_W-1:0] SPD_I_RST = 16'd67;
  localparam logic [GAIN_W-1:0] TURN_RST  = 16'd640;

  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd4;

  typedef enum logic [2:0] {
    MUL_KP_ANGLE,
    MUL_KD_PITCH,
    MUL_A_FILT,
    MUL_B_SPEED,
    MUL_SP_FILT,
    MUL_SI_INTEG,
    MUL_KT_YAW
  } mul_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_BALANCE,
    WR_FILTERED,
    WR_INTEGRAL,
    WR_SPEED,
    WR_STEER,
    WR_DRIVE,
    WR_OUT
  } wr_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     acc_clr;
    logic     acc_shift;
    wr_sel_e  wr_sel;
  } cmd_t;

  typedef struct packed {
    logic run;
  } status_t;

endpackage

// File: hw/rtl/balance_robot_cascade_control_unit.sv
// Top level of the cascaded balance, speed and steering controller for a two-wheeled robot.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   tilt, rates, pulses, motion cmd, flags
//   out      output     out_valid_o / out_ready_i reverse bits and duties, left and right
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i (16 bit)
//
// An item takes longer with the speed loop than without it, since the single shared
// multiplier forms the products one at a time: each product is a multiply step followed
// by an accumulate step. The next item can be accepted in the cycle after the result is loaded.
// The result register holds one finished item; a stalled output holds the sequencer in
// its last step until the register frees. Reset loads the default gains and clears state.
module balance_robot_cascade_control_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            tilt_angle_i,
  input  logic signed [23:0]            pitch_rate_i,
  input  logic signed [23:0]            yaw_rate_i,
  input  logic [11:0]                   left_pulses_i,
  input  logic [11:0]                   right_pulses_i,
  input  logic [bcc_pkg::CMD_W-1:0]     motion_cmd_i,
  input  logic                          run_speed_loop_i,
  input  logic                          halt_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          left_reverse_o,
  output logic [7:0]                    left_duty_o,
  output logic                          right_reverse_o,
  output logic [7:0]                    right_duty_o,
  input  logic                          cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bcc_pkg::GAIN_W-1:0]    cfg_data_i
);

  bcc_pkg::cmd_t    cmd;
  bcc_pkg::status_t status;

  bcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bcc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .tilt_angle_i     (tilt_angle_i),
    .pitch_rate_i     (pitch_rate_i),
    .yaw_rate_i       (yaw_rate_i),
    .left_pulses_i    (left_pulses_i),
    .right_pulses_i   (right_pulses_i),
    .motion_cmd_i     (motion_cmd_i),
    .run_speed_loop_i (run_speed_loop_i),
    .halt_i           (halt_i),
    .left_reverse_o   (left_reverse_o),
    .left_duty_o      (left_duty_o),
    .right_reverse_o  (right_reverse_o),
    .right_duty_o     (right_duty_o)
  );

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // item capture only on an accepted handshake
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid_i && in_ready_o))
    else $error("input captured without handshake");

  // a result load always presents the item
  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_sel == bcc_pkg::WR_OUT) |=> out_valid_o)
    else $error("result loaded but not presented");

  // the result register is never overwritten while an item still waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_sel == bcc_pkg::WR_OUT) |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

endmodule

// File: hw/rtl/bcc_ctrl.sv
// Sequencer that steps the shared multiply-accumulate datapath through one control tick.
module bcc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bcc_pkg::status_t status_i,
  output bcc_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M_KPA,
    ST_A_KPA,
    ST_M_KDP,
    ST_A_KDP,
    ST_M_AF,
    ST_A_AF,
    ST_M_BS,
    ST_A_BS,
    ST_W_FILT,
    ST_W_INTEG,
    ST_M_SPF,
    ST_A_SPF,
    ST_M_SIN,
    ST_A_SIN,
    ST_M_KTY,
    ST_A_KTY,
    ST_W_STEER,
    ST_W_DRIVE,
    ST_W_OUT
  } state_e;

  state_e        state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  bcc_pkg::cmd_t cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd.load      = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.mul_sel   = bcc_pkg::MUL_KP_ANGLE;
    cmd.acc_en    = 1'b0;
    cmd.acc_clr   = 1'b0;
    cmd.acc_shift = 1'b0;
    cmd.wr_sel    = bcc_pkg::WR_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_M_KPA;
        end
      end
      ST_M_KPA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bcc_pkg::MUL_KP_ANGLE;
        state_d     = ST_A_KPA;
      end
      ST_A_KPA: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_d     = ST_M_KDP;
      end
      ST_M_KDP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bcc_pkg::MUL_KD_PITCH;
        state_d     = ST_A_KDP;
      end
      ST_A_KDP: begin
        cmd.acc_en = 1'b1;
        state_d    = status_i.run ? ST_M_AF : ST_M_KTY;
      end
      ST_M_AF: begin
        cmd.wr_sel  = bcc_pkg::WR_BALANCE;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bcc_pkg::MUL_A_FILT;
        state_d     = ST_A_AF;
      end
      ST_A_AF: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_d     = ST_M_BS;
      end
      ST_M_BS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bcc_pkg::MUL_B_SPEED;
        state_d     = ST_A_BS;
      end
      ST_A_BS: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_shift = 1'b1;
        state_d       = ST_W_FILT;
      end
      ST_W_FILT: begin
        cmd.wr_sel = bcc_pkg::WR_FILTERED;
        state_d    = ST_W_INTEG;
      end
      ST_W_INTEG: begin
        cmd.wr_sel = bcc_pkg::WR_INTEGRAL;
        state_d    = ST_M_SPF;
      end
      ST_M_SPF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bcc_pkg::MUL_SP_FILT;
        state_d     = ST_A_SPF;
      end
      ST_A_SPF: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_d     = ST_M_SIN;
      end
      ST_M_SIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bcc_pkg::MUL_SI_INTEG;
        state_d     = ST_A_SIN;
      end
      ST_A_SIN: begin
        cmd.acc_en = 1'b1;
        state_d    = ST_M_KTY;
      end
      ST_M_KTY: begin
        cmd.wr_sel  = status_i.run ? bcc_pkg::WR_SPEED : bcc_pkg::WR_BALANCE;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bcc_pkg::MUL_KT_YAW;
        state_d     = ST_A_KTY;
      end
      ST_A_KTY: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_d     = ST_W_STEER;
      end
      ST_W_STEER: begin
        cmd.wr_sel = bcc_pkg::WR_STEER;
        state_d    = ST_W_DRIVE;
      end
      ST_W_DRIVE: begin
        cmd.wr_sel = bcc_pkg::WR_DRIVE;
        state_d    = ST_W_OUT;
      end
      ST_W_OUT: begin
        if (out_free) begin
          cmd.wr_sel  = bcc_pkg::WR_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: hw/rtl/bcc_datapath.sv
// Gain registers, loop state, shared multiplier with accumulator, and drive output registers.
module bcc_datapath #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bcc_pkg::cmd_t                         cmd_i,
  output bcc_pkg::status_t                      status_o,
  input  logic                                  cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bcc_pkg::GAIN_W-1:0]            cfg_data_i,
  input  logic signed [15:0]                    tilt_angle_i,
  input  logic signed [23:0]                    pitch_rate_i,
  input  logic signed [23:0]                    yaw_rate_i,
  input  logic [11:0]                           left_pulses_i,
  input  logic [11:0]                           right_pulses_i,
  input  logic [bcc_pkg::CMD_W-1:0]             motion_cmd_i,
  input  logic                                  run_speed_loop_i,
  input  logic                                  halt_i,
  output logic                                  left_reverse_o,
  output logic [7:0]                            left_duty_o,
  output logic                                  right_reverse_o,
  output logic [7:0]                            right_duty_o
);

  localparam int INTEG_W = FRAC_BITS + 13;
  localparam int B_W     = (INTEG_W > bcc_pkg::FILT_W) ? INTEG_W : bcc_pkg::FILT_W;
  localparam int A_W     = bcc_pkg::GAIN_W + 1;
  localparam int P_W     = A_W + B_W;
  localparam int ACC_W   = P_W + FRAC_BITS;
  localparam int SH_W    = ACC_W - FRAC_BITS;
  localparam int D_W     = SH_W + 3;
  localparam int SUM_W   = B_W + 2;
  localparam int PS_W    = bcc_pkg::PSUM_W + 1;

  localparam int ONE_I      = 1 << FRAC_BITS;
  localparam int COEF_OLD_I = (7 * ONE_I + 5) / 10;
  localparam logic [bcc_pkg::GAIN_W-1:0] COEF_OLD = bcc_pkg::GAIN_W'(COEF_OLD_I);
  localparam logic [bcc_pkg::GAIN_W-1:0] COEF_NEW = bcc_pkg::GAIN_W'(ONE_I - COEF_OLD_I);

  localparam logic signed [24:0] PITCH_OFS = 25'(64'sd1 <<< FRAC_BITS);

  localparam logic signed [PS_W-1:0] PSUM_HI =
    PS_W'((64'sd1 <<< (bcc_pkg::PSUM_W - 1)) - 64'sd1);
  localparam logic signed [PS_W-1:0] PSUM_LO = -PSUM_HI - PS_W'(1);

  localparam logic signed [SH_W-1:0] FILT_HI =
    SH_W'((64'sd1 <<< (bcc_pkg::FILT_W - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] FILT_LO = -FILT_HI - SH_W'(1);

  localparam logic signed [SH_W:0] TERM_HI =
    (SH_W + 1)'((64'sd1 <<< (bcc_pkg::TERM_W - 1)) - 64'sd1);
  localparam logic signed [SH_W:0] TERM_LO = -TERM_HI - (SH_W + 1)'(1);

  localparam logic signed [SUM_W-1:0] ILIM =
    SUM_W'(64'(bcc_pkg::INTEG_LIMIT) <<< FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SPEED_Q =
    SUM_W'(64'(bcc_pkg::SET_SPEED) <<< FRAC_BITS);
  localparam logic signed [SH_W:0] TURN_Q =
    (SH_W + 1)'(64'(bcc_pkg::SET_TURN) <<< FRAC_BITS);

  // gains
  logic [bcc_pkg::GAIN_W-1:0] bal_p_q, bal_d_q, spd_p_q, spd_i_q, turn_q;

  // captured item
  logic signed [15:0]        angle_q;
  logic signed [24:0]        pitch1_q;
  logic signed [23:0]        yaw_q;
  logic [bcc_pkg::CMD_W-1:0] mcmd_q;
  logic                      run_q, halt_q;

  // loop state
  logic signed [bcc_pkg::PSUM_W-1:0] lsum_q, rsum_q, lsum_d, rsum_d;
  logic                              lneg_q, rneg_q;
  logic signed [bcc_pkg::FILT_W-1:0] filt_q;
  logic signed [INTEG_W-1:0]         integ_q;
  logic signed [bcc_pkg::TERM_W-1:0] term_q;

  // working registers
  logic signed [PS_W-1:0]  ptot_q;
  logic signed [P_W-1:0]   p_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SH_W-1:0]  bal_q;
  logic signed [SH_W:0]    steer_q;
  logic signed [D_W-1:0]   ldrv_q, rdrv_q;
  logic                    lrev_q, rrev_q;
  logic [7:0]              lduty_q, rduty_q;

  logic signed [PS_W-1:0]     lp_s, rp_s, lnext, rnext;
  logic [bcc_pkg::GAIN_W-1:0] mul_a;
  logic signed [A_W-1:0]      mul_a_s;
  logic signed [B_W-1:0]      mul_b;
  logic signed [ACC_W-1:0]    p_ext, addend;
  logic signed [SH_W-1:0]     sh;
  logic signed [SH_W:0]       neg_sh;
  logic signed [bcc_pkg::FILT_W-1:0] filt_new;
  logic signed [bcc_pkg::TERM_W-1:0] term_new;
  logic signed [SUM_W-1:0]    set_speed, isum;
  logic signed [INTEG_W-1:0]  integ_new;
  logic signed [SH_W:0]       set_turn;
  logic [D_W-1:0]             lmag, rmag, lint, rint;
  logic [7:0]                 lduty_new, rduty_new;

  // pulse accumulation, signed by the previous drive direction
  always_comb begin
    lp_s  = PS_W'(signed'({1'b0, left_pulses_i}));
    rp_s  = PS_W'(signed'({1'b0, right_pulses_i}));
    lnext = PS_W'(lsum_q) + (lneg_q ? -lp_s : lp_s);
    rnext = PS_W'(rsum_q) + (rneg_q ? -rp_s : rp_s);
    if (lnext > PSUM_HI) begin
      lsum_d = bcc_pkg::PSUM_W'(PSUM_HI);
    end else if (lnext < PSUM_LO) begin
      lsum_d = bcc_pkg::PSUM_W'(PSUM_LO);
    end else begin
      lsum_d = bcc_pkg::PSUM_W'(lnext);
    end
    if (rnext > PSUM_HI) begin
      rsum_d = bcc_pkg::PSUM_W'(PSUM_HI);
    end else if (rnext < PSUM_LO) begin
      rsum_d = bcc_pkg::PSUM_W'(PSUM_LO);
    end else begin
      rsum_d = bcc_pkg::PSUM_W'(rnext);
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      bcc_pkg::MUL_KP_ANGLE: begin
        mul_a = bal_p_q;
        mul_b = B_W'(angle_q);
      end
      bcc_pkg::MUL_KD_PITCH: begin
        mul_a = bal_d_q;
        mul_b = B_W'(pitch1_q);
      end
      bcc_pkg::MUL_A_FILT: begin
        mul_a = COEF_OLD;
        mul_b = B_W'(filt_q);
      end
      bcc_pkg::MUL_B_SPEED: begin
        mul_a = COEF_NEW;
        mul_b = B_W'(ptot_q);
      end
      bcc_pkg::MUL_SP_FILT: begin
        mul_a = spd_p_q;
        mul_b = B_W'(filt_q);
      end
      bcc_pkg::MUL_SI_INTEG: begin
        mul_a = spd_i_q;
        mul_b = B_W'(integ_q);
      end
      bcc_pkg::MUL_KT_YAW: begin
        mul_a = turn_q;
        mul_b = B_W'(yaw_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_a_s = signed'({1'b0, mul_a});

  // accumulate; speed sample is (L+R)*2^(F-1), the shift is applied after the product
  always_comb begin
    p_ext  = ACC_W'(p_q);
    addend = cmd_i.acc_shift ? (p_ext <<< (FRAC_BITS - 1)) : p_ext;
    acc_d  = (cmd_i.acc_clr ? '0 : acc_q) + addend;
  end

  assign sh     = SH_W'(acc_q >>> FRAC_BITS);
  assign neg_sh = -((SH_W + 1)'(sh));

  always_comb begin
    if (sh > FILT_HI) begin
      filt_new = bcc_pkg::FILT_W'(FILT_HI);
    end else if (sh < FILT_LO) begin
      filt_new = bcc_pkg::FILT_W'(FILT_LO);
    end else begin
      filt_new = bcc_pkg::FILT_W'(sh);
    end
    if (neg_sh > TERM_HI) begin
      term_new = bcc_pkg::TERM_W'(TERM_HI);
    end else if (neg_sh < TERM_LO) begin
      term_new = bcc_pkg::TERM_W'(TERM_LO);
    end else begin
      term_new = bcc_pkg::TERM_W'(neg_sh);
    end
  end

  // setpoints
  always_comb begin
    set_speed = '0;
    set_turn  = '0;
    case (mcmd_q)
      bcc_pkg::CMD_FWD:   set_speed = SPEED_Q;
      bcc_pkg::CMD_BACK:  set_speed = -SPEED_Q;
      bcc_pkg::CMD_LEFT:  set_turn  = TURN_Q;
      bcc_pkg::CMD_RIGHT: set_turn  = -TURN_Q;
      default: begin
        set_speed = '0;
        set_turn  = '0;
      end
    endcase
  end

  always_comb begin
    isum = SUM_W'(integ_q) + SUM_W'(filt_q) - set_speed;
    if (isum > ILIM) begin
      integ_new = INTEG_W'(ILIM);
    end else if (isum < -ILIM) begin
      integ_new = INTEG_W'(-ILIM);
    end else begin
      integ_new = INTEG_W'(isum);
    end
  end

  // duty: magnitude with fraction dropped, clamped to full scale
  always_comb begin
    lmag      = ldrv_q[D_W-1] ? D_W'(-ldrv_q) : D_W'(ldrv_q);
    rmag      = rdrv_q[D_W-1] ? D_W'(-rdrv_q) : D_W'(rdrv_q);
    lint      = lmag >> FRAC_BITS;
    rint      = rmag >> FRAC_BITS;
    lduty_new = (lint > D_W'(bcc_pkg::DUTY_MAX)) ? bcc_pkg::DUTY_MAX : lint[7:0];
    rduty_new = (rint > D_W'(bcc_pkg::DUTY_MAX)) ? bcc_pkg::DUTY_MAX : rint[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_p_q <= bcc_pkg::BAL_P_RST;
      bal_d_q <= bcc_pkg::BAL_D_RST;
      spd_p_q <= bcc_pkg::SPD_P_RST;
      spd_i_q <= bcc_pkg::SPD_I_RST;
      turn_q  <= bcc_pkg::TURN_RST;
      lsum_q  <= '0;
      rsum_q  <= '0;
      lneg_q  <= 1'b0;
      rneg_q  <= 1'b0;
      filt_q  <= '0;
      integ_q <= '0;
      term_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bcc_pkg::REG_BAL_P: bal_p_q <= cfg_data_i;
          bcc_pkg::REG_BAL_D: bal_d_q <= cfg_data_i;
          bcc_pkg::REG_SPD_P: spd_p_q <= cfg_data_i;
          bcc_pkg::REG_SPD_I: spd_i_q <= cfg_data_i;
          bcc_pkg::REG_TURN:  turn_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        lsum_q <= lsum_d;
        rsum_q <= rsum_d;
      end
      case (cmd_i.wr_sel)
        bcc_pkg::WR_FILTERED: begin
          filt_q <= filt_new;
          lsum_q <= '0;
          rsum_q <= '0;
        end
        bcc_pkg::WR_INTEGRAL: integ_q <= integ_new;
        bcc_pkg::WR_SPEED:    term_q  <= term_new;
        bcc_pkg::WR_OUT: begin
          lneg_q <= ldrv_q[D_W-1];
          rneg_q <= rdrv_q[D_W-1];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ptot_q <= PS_W'(lsum_q) + PS_W'(rsum_q);
    if (cmd_i.load) begin
      angle_q  <= tilt_angle_i;
      pitch1_q <= 25'(pitch_rate_i) + PITCH_OFS;
      yaw_q    <= yaw_rate_i;
      mcmd_q   <= motion_cmd_i;
      run_q    <= run_speed_loop_i;
      halt_q   <= halt_i;
    end
    if (cmd_i.mul_en) begin
      p_q <= P_W'(mul_a_s) * P_W'(mul_b);
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    case (cmd_i.wr_sel)
      bcc_pkg::WR_BALANCE: bal_q   <= sh;
      bcc_pkg::WR_STEER:   steer_q <= set_turn + (SH_W + 1)'(sh);
      bcc_pkg::WR_DRIVE: begin
        ldrv_q <= D_W'(bal_q) - D_W'(term_q) - D_W'(steer_q);
        rdrv_q <= D_W'(bal_q) - D_W'(term_q) + D_W'(steer_q);
      end
      bcc_pkg::WR_OUT: begin
        lrev_q  <= ldrv_q[D_W-1];
        rrev_q  <= rdrv_q[D_W-1];
        lduty_q <= halt_q ? 8'd0 : lduty_new;
        rduty_q <= halt_q ? 8'd0 : rduty_new;
      end
      default: ;
    endcase
  end

  assign status_o.run    = run_q;
  assign left_reverse_o  = lrev_q;
  assign left_duty_o     = lduty_q;
  assign right_reverse_o = rrev_q;
  assign right_duty_o    = rduty_q;

endmodule

// File: verif/tb.sv
// Testbench for the balance cascade controller: directed and random ticks checked by a predictor.
`timescale 1ns / 1ps

module tb;
  import bcc_pkg::*;

  localparam int     FRAC      = 8;
  localparam longint ONE       = longint'(1) << FRAC;
  localparam longint COEF_OLD  = (7 * ONE + 5) / 10;
  localparam longint COEF_NEW  = ONE - COEF_OLD;
  localparam longint INTEG_MAX = INTEG_LIMIT * ONE;
  localparam longint DUTY_CAP  = longint'(DUTY_MAX) * ONE;
  localparam int     LIMIT     = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [15:0] tilt;
    logic signed [23:0] pitch;
    logic signed [23:0] yaw;
    logic [11:0]        lp;
    logic [11:0]        rp;
    logic [CMD_W-1:0]   cmd;
    logic               run;
    logic               halt;
  } tick_t;

  typedef struct {
    logic       l_rev;
    logic [7:0] l_duty;
    logic       r_rev;
    logic [7:0] r_duty;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;
  tick_t cur = '{default: '0};

  wire in_ready;
  wire out_valid;
  wire l_rev_o, r_rev_o;
  wire [7:0] l_duty_o, r_duty_o;
  wire in_fire = in_valid && in_ready;

  tick_t  pending_ticks[$];
  drive_t expected_drives[$];
  int     idle_pct = 7;
  int     mismatches = 0;
  int     cycles = 0;

  logic [GAIN_W-1:0] gains [5];
  longint l_acc, r_acc, spd_filt, spd_integ, spd_out;
  logic   l_back, r_back;

  balance_robot_cascade_control_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .tilt_angle_i    (cur.tilt),
    .pitch_rate_i    (cur.pitch),
    .yaw_rate_i      (cur.yaw),
    .left_pulses_i   (cur.lp),
    .right_pulses_i  (cur.rp),
    .motion_cmd_i    (cur.cmd),
    .run_speed_loop_i(cur.run),
    .halt_i          (cur.halt),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .left_reverse_o  (l_rev_o),
    .left_duty_o     (l_duty_o),
    .right_reverse_o (r_rev_o),
    .right_duty_o    (r_duty_o),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint sat_signed(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic logic [7:0] duty_of(longint d);
    longint mag;
    mag = d < 0 ? -d : d;
    if (mag > DUTY_CAP) mag = DUTY_CAP;
    return 8'(mag >>> FRAC);
  endfunction

  function automatic drive_t predict_drives(tick_t t);
    longint set_spd, set_trn, bal, spd, steer, l, r;
    drive_t d;
    set_spd = 0;
    set_trn = 0;
    case (t.cmd)
      CMD_FWD:   set_spd = SET_SPEED;
      CMD_BACK:  set_spd = -SET_SPEED;
      CMD_LEFT:  set_trn = SET_TURN;
      CMD_RIGHT: set_trn = -SET_TURN;
      default: ;
    endcase
    l_acc = sat_signed(l_acc + (l_back ? -longint'(t.lp) : longint'(t.lp)), PSUM_W);
    r_acc = sat_signed(r_acc + (r_back ? -longint'(t.rp) : longint'(t.rp)), PSUM_W);
    bal = (longint'(gains[REG_BAL_P]) * longint'(t.tilt) +
           longint'(gains[REG_BAL_D]) * (longint'(t.pitch) + ONE)) >>> FRAC;
    if (t.run) begin
      spd = (l_acc + r_acc) * (ONE / 2);
      l_acc = 0;
      r_acc = 0;
      spd_filt = sat_signed((COEF_OLD * spd_filt + COEF_NEW * spd) >>> FRAC, FILT_W);
      spd_integ = spd_integ + spd_filt - set_spd * ONE;
      if (spd_integ > INTEG_MAX) spd_integ = INTEG_MAX;
      if (spd_integ < -INTEG_MAX) spd_integ = -INTEG_MAX;
      spd_out = sat_signed(-((longint'(gains[REG_SPD_P]) * spd_filt +
                              longint'(gains[REG_SPD_I]) * spd_integ) >>> FRAC), TERM_W);
    end
    steer = set_trn * ONE + ((longint'(gains[REG_TURN]) * longint'(t.yaw)) >>> FRAC);
    l = bal - spd_out - steer;
    r = bal - spd_out + steer;
    l_back = l < 0;
    r_back = r < 0;
    d.l_rev  = l_back;
    d.l_duty = t.halt ? 8'd0 : duty_of(l);
    d.r_rev  = r_back;
    d.r_duty = t.halt ? 8'd0 : duty_of(r);
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) expected_drives.push_back(predict_drives(cur));
      if (!in_valid || in_fire) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    drive_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("result with no tick pending");
        end else begin
          e = expected_drives.pop_front();
          if (l_rev_o !== e.l_rev || l_duty_o !== e.l_duty ||
              r_rev_o !== e.r_rev || r_duty_o !== e.r_duty)
            report_mismatch($sformatf("got L %b/%0d R %b/%0d, exp L %b/%0d R %b/%0d",
                                      l_rev_o, l_duty_o, r_rev_o, r_duty_o,
                                      e.l_rev, e.l_duty, e.r_rev, e.r_duty));
        end
      end
      out_ready <= $urandom_range(99) >= idle_pct;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("balance_robot_cascade_control_unit test failed");
      $finish;
    end
  end

  task automatic set_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx <= REG_TURN) gains[idx] = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid || expected_drives.size() != 0)
      @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic push_tick(input int tilt, input int pitch, input int yaw, input int lp,
                           input int rp, input logic [CMD_W-1:0] cmd, input bit run,
                           input bit halt);
    tick_t t;
    t.tilt  = 16'(tilt);
    t.pitch = 24'(pitch);
    t.yaw   = 24'(yaw);
    t.lp    = 12'(lp);
    t.rp    = 12'(rp);
    t.cmd   = cmd;
    t.run   = run;
    t.halt  = halt;
    pending_ticks.push_back(t);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    if ($urandom_range(99) < 70) begin
      t.tilt  = 16'(int'($urandom_range(5120)) - 2560);
      t.pitch = 24'(int'($urandom_range(102400)) - 51200);
      t.yaw   = 24'(int'($urandom_range(51200)) - 25600);
      t.lp    = 12'($urandom_range(60));
      t.rp    = 12'($urandom_range(60));
      t.cmd   = $urandom_range(9) == 0 ? 3'($urandom_range(7, CMD_RIGHT + 1))
                                       : 3'($urandom_range(CMD_RIGHT));
      t.run   = $urandom_range(3) == 0;
      t.halt  = $urandom_range(9) == 0;
    end else begin
      t.tilt  = 16'($urandom);
      t.pitch = 24'($urandom);
      t.yaw   = 24'($urandom);
      t.lp    = 12'($urandom);
      t.rp    = 12'($urandom);
      t.cmd   = 3'($urandom_range(7));
      t.run   = 1'($urandom_range(1));
      t.halt  = 1'($urandom_range(1));
    end
    return t;
  endfunction

  initial begin
    gains[REG_BAL_P] = BAL_P_RST;
    gains[REG_BAL_D] = BAL_D_RST;
    gains[REG_SPD_P] = SPD_P_RST;
    gains[REG_SPD_I] = SPD_I_RST;
    gains[REG_TURN]  = TURN_RST;
    l_acc = 0;
    r_acc = 0;
    spd_filt = 0;
    spd_integ = 0;
    spd_out = 0;
    l_back = 1'b0;
    r_back = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // drives just below zero, then field extremes
    push_tick(0, -257, 0, 0, 0, CMD_STOP, 0, 0);
    push_tick(0, -512, 0, 0, 0, CMD_STOP, 0, 0);
    push_tick(0, 0, 0, 0, 0, CMD_STOP, 0, 0);
    push_tick(32767, 8388607, 0, 4095, 4095, CMD_STOP, 0, 0);
    push_tick(-32768, -8388608, 0, 4095, 4095, CMD_STOP, 0, 0);
    push_tick(0, 0, 8388607, 4095, 0, CMD_LEFT, 0, 0);
    push_tick(0, 0, -8388608, 0, 4095, CMD_RIGHT, 0, 0);
    push_tick(0, 0, 1, 7, 3, CMD_LEFT, 0, 0);
    push_tick(0, 0, -1, 3, 7, CMD_RIGHT, 0, 0);
    push_tick(256, 0, 0, 100, 100, CMD_FWD, 1, 0);
    push_tick(-256, 0, 0, 100, 100, CMD_BACK, 1, 0);
    for (int c = CMD_RIGHT + 1; c < 8; c++) push_tick(512, 0, 256, 5, 5, 3'(c), 0, 0);
    push_tick(32767, 0, 0, 10, 10, CMD_FWD, 0, 1);
    push_tick(-32768, 0, 0, 10, 10, CMD_BACK, 1, 1);
    push_tick(0, 0, 0, 0, 0, CMD_STOP, 1, 0);
    push_tick(32767, 8388607, 8388607, 4095, 4095, CMD_LEFT, 1, 0);
    push_tick(-32768, -8388608, -8388608, 4095, 4095, CMD_RIGHT, 1, 1);
    wait_drained();

    // pulse sums run into saturation, then the speed loop takes them
    for (int i = 0; i < 135; i++)
      push_tick(32767, 0, 0, 4095, 4095, CMD_STOP, 0, $urandom_range(7) == 0);
    repeat (5) push_tick(0, 0, 0, $urandom_range(4095), $urandom_range(4095),
                         3'($urandom_range(CMD_RIGHT)), 1, 0);
    repeat (60) pending_ticks.push_back(rand_tick());
    wait_drained();

    for (int i = REG_BAL_P; i <= REG_TURN; i++) set_gain(3'(i), 16'hFFFF);
    repeat (80) pending_ticks.push_back(rand_tick());
    wait_drained();

    for (int i = REG_BAL_P; i <= REG_TURN; i++) set_gain(3'(i), 16'h0000);
    set_gain(REG_NONE, 16'h1234);
    repeat (30) pending_ticks.push_back(rand_tick());
    wait_drained();

    for (int i = REG_BAL_P; i <= REG_TURN; i++) set_gain(3'(i), 16'($urandom_range(65535)));
    idle_pct = 0;
    repeat (80) pending_ticks.push_back(rand_tick());
    wait_drained();

    idle_pct = 7;
    set_gain(REG_BAL_P, BAL_P_RST);
    set_gain(REG_BAL_D, BAL_D_RST);
    set_gain(REG_SPD_P, SPD_P_RST);
    set_gain(REG_SPD_I, SPD_I_RST);
    set_gain(REG_TURN, TURN_RST);
    repeat (60) pending_ticks.push_back(rand_tick());
    wait_drained();

    if (mismatches == 0) begin
      $display("balance_robot_cascade_control_unit test passed");
    end else begin
      $display("balance_robot_cascade_control_unit test failed");
    end
    $finish;
  end

endmodule
